### rtl/core/rtzm_pkg.sv
// ----------------------------------------------------------------------------
// rtzm_pkg
// shared types and codes for the rotate-and-zoom tile address generator
// ----------------------------------------------------------------------------
package rtzm_pkg;

    localparam int ACC_W      = 24;
    localparam int ORIGIN_W   = 16;
    localparam int STEP_W     = 16;
    localparam int BANK_W     = 13;
    localparam int CTRL_W     = 8;
    localparam int CPU_ADDR_W = 11;
    localparam int BYTE_W     = 8;
    localparam int MAP_IDX_W  = 10;
    localparam int MAP_DEPTH  = 1 << MAP_IDX_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // control register bit positions
    localparam int CTRL_CPU_OWNS = 7;
    localparam int CTRL_TEST     = 6;
    localparam int CTRL_YFLIP_EN = 2;
    localparam int CTRL_XFLIP_EN = 1;
    localparam int CTRL_TILE     = 0;

    typedef enum logic [2:0] {
        OP_FRAME = 3'd0,
        OP_LINE  = 3'd1,
        OP_PIXEL = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_ORIGIN     = 3'd0,
        REG_Y_ORIGIN     = 3'd1,
        REG_X_STEP_PIXEL = 3'd2,
        REG_X_STEP_LINE  = 3'd3,
        REG_Y_STEP_PIXEL = 3'd4,
        REG_Y_STEP_LINE  = 3'd5,
        REG_ROM_BANK     = 3'd6,
        REG_CONTROL_BITS = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0]            opcode;
        logic [CPU_ADDR_W-1:0] cpu_address;
        logic [BYTE_W-1:0]     cpu_byte;
    } in_item_t;

    typedef struct packed {
        logic [ACC_W-1:0]  rom_address;
        logic              outside_window;
        logic [BYTE_W-1:0] read_byte;
    } out_item_t;

endpackage

### rtl/core/rotozoom_tile_address_generator.sv
// ----------------------------------------------------------------------------
// rotozoom_tile_address_generator
// affine rotate-and-zoom plane walker with a 32x32 tile map and rom address out
// ----------------------------------------------------------------------------
//  channel | signals                          | direction | item
//  --------+----------------------------------+-----------+---------------------
//  in      | in_valid, in_ready, in_item      | input     | opcode, cpu addr/byte
//  out     | out_valid, out_ready, out_item   | output    | rom addr, window, byte
//  cfg     | cfg_write, cfg_index, cfg_data   | input     | register write
//
//  one item per clock sustained while the output is not stalled; out_valid rises
//  when the accepted item moves on from the map ram read register and middle
//  stage into the result register, which happens once that register is free or drains
//  the accumulator update and the map ram write happen at the accept edge
//  reset clears accumulators, config registers and the valid flags; map rams
//  hold garbage until written and are never cleared
//  a stalled output holds the middle stage, and the input stalls only when
//  both the middle stage and the result register are full and out_ready is low
// ----------------------------------------------------------------------------
module rotozoom_tile_address_generator
    import rtzm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [ORIGIN_W-1:0] x_origin_reg, y_origin_reg;
    logic [STEP_W-1:0]   x_step_pixel_reg, x_step_line_reg;
    logic [STEP_W-1:0]   y_step_pixel_reg, y_step_line_reg;
    logic [BANK_W-1:0]   rom_bank_reg;
    logic [CTRL_W-1:0]   control_reg;

    // plane accumulators and their line-start copies
    logic [ACC_W-1:0] x_acc_reg, y_acc_reg, x_line_reg, y_line_reg;
    logic [ACC_W-1:0] x_acc_next, y_acc_next, x_line_next, y_line_next;

    // tile map rams
    logic [BYTE_W-1:0] map_hi_mem [MAP_DEPTH];
    logic [BYTE_W-1:0] map_lo_mem [MAP_DEPTH];
    logic [BYTE_W-1:0] tile_hi_reg, tile_lo_reg;   // word read at tile index
    logic [BYTE_W-1:0] cpu_hi_reg, cpu_lo_reg;     // bytes read at cpu entry

    // middle stage
    logic                  s1_valid_reg;
    logic                  s1_is_read_reg;
    logic                  s1_hi_sel_reg;
    logic                  s1_hit_hi_reg, s1_hit_lo_reg;
    logic [CPU_ADDR_W-1:0] s1_addr_reg;
    logic [BYTE_W-1:0]     s1_byte_reg;

    // result register
    logic      out_valid_reg;
    out_item_t out_item_reg, out_item_next;

    logic                 accept;
    logic                 s1_advance;
    op_t                  op;
    logic                 hi_sel;
    logic [MAP_IDX_W-1:0] entry;
    logic [MAP_IDX_W-1:0] tile_idx;
    logic                 is_write;

    // handshake: middle stage moves whenever the result register is free or drains
    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_item   = out_item_reg;

    assign op       = op_t'(in_item.opcode);
    assign hi_sel   = in_item.cpu_address[CPU_ADDR_W-1];
    assign entry    = in_item.cpu_address[MAP_IDX_W-1:0];
    assign is_write = (op == OP_WRITE);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg     <= '0;
            y_origin_reg     <= '0;
            x_step_pixel_reg <= '0;
            x_step_line_reg  <= '0;
            y_step_pixel_reg <= '0;
            y_step_line_reg  <= '0;
            rom_bank_reg     <= '0;
            control_reg      <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_X_ORIGIN:     x_origin_reg     <= cfg_data;
                REG_Y_ORIGIN:     y_origin_reg     <= cfg_data;
                REG_X_STEP_PIXEL: x_step_pixel_reg <= cfg_data;
                REG_X_STEP_LINE:  x_step_line_reg  <= cfg_data;
                REG_Y_STEP_PIXEL: y_step_pixel_reg <= cfg_data;
                REG_Y_STEP_LINE:  y_step_line_reg  <= cfg_data;
                REG_ROM_BANK:     rom_bank_reg     <= cfg_data[BANK_W-1:0];
                REG_CONTROL_BITS: control_reg      <= cfg_data[CTRL_W-1:0];
            endcase
        end
    end

    // accumulator update, one 24-bit add per axis, wraps mod 2^24
    always_comb
    begin
        x_acc_next  = x_acc_reg;
        y_acc_next  = y_acc_reg;
        x_line_next = x_line_reg;
        y_line_next = y_line_reg;
        case (op)
            OP_FRAME:
            begin
                x_acc_next  = {x_origin_reg, 8'h00};
                y_acc_next  = {y_origin_reg, 8'h00};
                x_line_next = {x_origin_reg, 8'h00};
                y_line_next = {y_origin_reg, 8'h00};
            end
            OP_LINE:
            begin
                x_line_next = x_line_reg + {{(ACC_W-STEP_W){x_step_line_reg[STEP_W-1]}},
                                            x_step_line_reg};
                y_line_next = y_line_reg + {{(ACC_W-STEP_W){y_step_line_reg[STEP_W-1]}},
                                            y_step_line_reg};
                x_acc_next  = x_line_next;
                y_acc_next  = y_line_next;
            end
            OP_PIXEL:
            begin
                x_acc_next = x_acc_reg + {{(ACC_W-STEP_W){x_step_pixel_reg[STEP_W-1]}},
                                          x_step_pixel_reg};
                y_acc_next = y_acc_reg + {{(ACC_W-STEP_W){y_step_pixel_reg[STEP_W-1]}},
                                          y_step_pixel_reg};
            end
            default:
            begin
                // map access and unused codes leave the walk alone
            end
        endcase
    end

    // map entry for the tile under the new position, or the cpu entry
    assign tile_idx = control_reg[CTRL_CPU_OWNS] ? entry
                                                 : {y_acc_next[19:15], x_acc_next[19:15]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_acc_reg  <= '0;
            y_acc_reg  <= '0;
            x_line_reg <= '0;
            y_line_reg <= '0;
        end
        else if (accept)
        begin
            x_acc_reg  <= x_acc_next;
            y_acc_reg  <= y_acc_next;
            x_line_reg <= x_line_next;
            y_line_reg <= y_line_next;
        end
    end

    // map rams: one write port, two registered read ports, read-old on collision
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (is_write && hi_sel)
            begin
                map_hi_mem[entry] <= in_item.cpu_byte;
            end
            if (is_write && !hi_sel)
            begin
                map_lo_mem[entry] <= in_item.cpu_byte;
            end
            tile_hi_reg <= map_hi_mem[tile_idx];
            tile_lo_reg <= map_lo_mem[tile_idx];
            cpu_hi_reg  <= map_hi_mem[entry];
            cpu_lo_reg  <= map_lo_mem[entry];
        end
    end

    // middle stage: item info plus write-forward flags for the tile word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_is_read_reg <= (op == OP_READ);
            s1_hi_sel_reg  <= hi_sel;
            s1_hit_hi_reg  <= is_write && hi_sel && (tile_idx == entry);
            s1_hit_lo_reg  <= is_write && !hi_sel && (tile_idx == entry);
            s1_addr_reg    <= in_item.cpu_address;
            s1_byte_reg    <= in_item.cpu_byte;
        end
    end

    // result: accumulators already hold this item's values while it sits in s1
    always_comb
    begin
        logic [BYTE_W-1:0] word_hi, word_lo;
        logic [3:0]        x_fine, y_fine;

        word_hi = s1_hit_hi_reg ? s1_byte_reg : tile_hi_reg;
        word_lo = s1_hit_lo_reg ? s1_byte_reg : tile_lo_reg;
        x_fine  = x_acc_reg[14:11];
        y_fine  = y_acc_reg[14:11];
        if (control_reg[CTRL_XFLIP_EN] && word_hi[6])
        begin
            x_fine = ~x_fine;
        end
        if (control_reg[CTRL_YFLIP_EN] && word_hi[7])
        begin
            y_fine = ~y_fine;
        end

        if (control_reg[CTRL_TEST])
        begin
            out_item_next.rom_address = control_reg[CTRL_TILE] ? x_acc_reg : y_acc_reg;
        end
        else if (control_reg[CTRL_TILE])
        begin
            out_item_next.rom_address = {word_hi, word_lo, y_fine, x_fine};
        end
        else
        begin
            out_item_next.rom_address = {rom_bank_reg, s1_addr_reg};
        end

        out_item_next.outside_window = (x_acc_reg[23:20] != 4'h0) ||
                                       (y_acc_reg[23:20] != 4'h0);

        if (s1_is_read_reg)
        begin
            out_item_next.read_byte = s1_hi_sel_reg ? cpu_hi_reg : cpu_lo_reg;
        end
        else
        begin
            out_item_next.read_byte = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // a frame start lines both accumulators up with their line-start copies
    a_frame_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_FRAME) |=>
            (x_acc_reg == x_line_reg) && (y_acc_reg == y_line_reg))
        else $error("frame start left accumulator and line copy apart");

    // a pixel step never touches the line-start copies
    a_pixel_line_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_PIXEL) |=> $stable(x_line_reg) && $stable(y_line_reg))
        else $error("pixel step changed a line-start copy");

    // map accesses leave the plane walk untouched
    a_map_op_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_WRITE || op == OP_READ)) |=>
            $stable(x_acc_reg) && $stable(y_acc_reg))
        else $error("map access moved an accumulator");

    // an item in the middle stage is never dropped while the output stalls
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> s1_valid_reg && $stable(s1_addr_reg))
        else $error("middle stage lost an item under stall");

    // the window flag follows the accumulators the item left behind
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_advance) |=>
            out_valid_reg &&
            (out_item_reg.outside_window ==
             (($past(x_acc_reg[23:20]) != 4'h0) || ($past(y_acc_reg[23:20]) != 4'h0))))
        else $error("window flag does not match accumulators");

endmodule
